@@ sv/ftrl_proximal_update_top_defines.svh @@
// Assertion macros shared by the FTRL-Proximal update RTL.
`ifndef FTRL_PROXIMAL_UPDATE_TOP_DEFINES_SVH
`define FTRL_PROXIMAL_UPDATE_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Condition on the left implies the property on the right, same clock edge.
`define FTRL_ASSERT_IMPLIES(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("ftrl assertion failed");
// Condition must never hold.
`define FTRL_ASSERT_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("ftrl assertion failed");
`else
`define FTRL_ASSERT_IMPLIES(label, pre, post)
`define FTRL_ASSERT_NEVER(label, cond)
`endif
`endif

@@ sv/ftrl_pkg.sv @@
// Package with widths, types and step functions of the FTRL-Proximal update.
package ftrl_pkg;

    localparam int DW             = 32;
    localparam int FRAC           = 16;
    localparam int PROD_W         = 2 * DW;
    localparam int ROOT_W         = (DW + FRAC) / 2;
    localparam int RAD_W          = 2 * ROOT_W;
    localparam int REM_W          = ROOT_W + 2;
    localparam int SQRT_PER_STAGE = 2;
    localparam int SQRT_STAGES    = ROOT_W / SQRT_PER_STAGE;
    localparam int SIGP_W         = ROOT_W + DW;
    localparam int SW_W           = PROD_W + 1 - FRAC;
    localparam int DEN_W          = PROD_W - FRAC + 1;
    localparam int DREM_W         = DEN_W + 1;
    localparam int DIV_PER_STAGE  = 2;
    localparam int DIV_STAGES     = DW / DIV_PER_STAGE;
    localparam int LATENCY        = 3 + SQRT_STAGES + 6 + DIV_STAGES + 1;

    localparam logic [DW-1:0] SMAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] SMIN = {1'b1, {(DW-1){1'b0}}};

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_ALPHA_INV  = 2'd0,
        REG_BETA       = 2'd1,
        REG_LAMBDA_ONE = 2'd2,
        REG_LAMBDA_TWO = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic signed [DW-1:0] weight;
        logic        [DW-1:0] sq_grad_sum;
        logic signed [DW-1:0] z_acc;
        logic signed [DW-1:0] gradient;
    } cmd_t;

    typedef struct packed {
        logic signed [DW-1:0] new_weight;
        logic        [DW-1:0] new_sq_grad_sum;
        logic signed [DW-1:0] new_z_acc;
    } result_t;

    // Values that ride along with the square root pipeline.
    typedef struct packed {
        logic signed [DW-1:0] w;
        logic signed [DW-1:0] z;
        logic signed [DW-1:0] g;
        logic        [DW-1:0] nn;
    } sq_side_t;

    // Values that ride along with the divider pipeline.
    typedef struct packed {
        logic        [DW-1:0] nn;
        logic signed [DW-1:0] nz;
        logic                 active;
        logic                 ovf;
    } dv_side_t;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } sq_state_t;

    typedef struct packed {
        logic [DREM_W-1:0] rem;
        logic [DW-1:0]     quot;
    } div_state_t;

    // One digit of the restoring integer square root.
    function automatic sq_state_t sqrt_step(sq_state_t s, logic [1:0] pair);
        logic [REM_W-1:0] r;
        logic [REM_W-1:0] trial;
        sq_state_t        o;
        r     = {s.rem[REM_W-3:0], pair};
        trial = {s.root, 2'b01};
        if (r >= trial)
        begin
            o.rem  = r - trial;
            o.root = {s.root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            o.rem  = r;
            o.root = {s.root[ROOT_W-2:0], 1'b0};
        end
        return o;
    endfunction

    // One quotient bit of the restoring division.
    function automatic div_state_t div_step(div_state_t s, logic din,
                                            logic [DEN_W-1:0] den);
        logic [DREM_W-1:0] r;
        div_state_t        o;
        r = {s.rem[DREM_W-2:0], din};
        if (r >= {1'b0, den})
        begin
            o.rem  = r - {1'b0, den};
            o.quot = {s.quot[DW-2:0], 1'b1};
        end
        else
        begin
            o.rem  = r;
            o.quot = {s.quot[DW-2:0], 1'b0};
        end
        return o;
    endfunction

endpackage

@@ sv/ftrl_sqrt_pipe.sv @@
// Pipelined square roots of the old and new squared-gradient sums.
module ftrl_sqrt_pipe (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic [ftrl_pkg::RAD_W-1:0]  in_rad_new,
    input  logic [ftrl_pkg::RAD_W-1:0]  in_rad_old,
    input  ftrl_pkg::sq_side_t       in_side,
    output logic                     out_valid,
    output logic [ftrl_pkg::ROOT_W-1:0] out_root_new,
    output logic [ftrl_pkg::ROOT_W-1:0] out_root_old,
    output ftrl_pkg::sq_side_t       out_side
);
    import ftrl_pkg::*;

    logic [SQRT_STAGES-1:0] valid_reg;
    sq_state_t              new_st_reg  [SQRT_STAGES];
    sq_state_t              new_st_next [SQRT_STAGES];
    sq_state_t              old_st_reg  [SQRT_STAGES];
    sq_state_t              old_st_next [SQRT_STAGES];
    logic [RAD_W-1:0]       new_rad_reg  [SQRT_STAGES];
    logic [RAD_W-1:0]       new_rad_next [SQRT_STAGES];
    logic [RAD_W-1:0]       old_rad_reg  [SQRT_STAGES];
    logic [RAD_W-1:0]       old_rad_next [SQRT_STAGES];
    sq_side_t               side_reg  [SQRT_STAGES];
    sq_side_t               side_next [SQRT_STAGES];

    // Each stage resolves two root bits for both lanes.
    always_comb
    begin
        sq_state_t        ns;
        sq_state_t        os;
        logic [RAD_W-1:0] nr;
        logic [RAD_W-1:0] orad;
        for (int j = 0; j < SQRT_STAGES; j++)
        begin
            if (j == 0)
            begin
                ns           = '0;
                os           = '0;
                nr           = in_rad_new;
                orad         = in_rad_old;
                side_next[j] = in_side;
            end
            else
            begin
                ns           = new_st_reg[j-1];
                os           = old_st_reg[j-1];
                nr           = new_rad_reg[j-1];
                orad         = old_rad_reg[j-1];
                side_next[j] = side_reg[j-1];
            end
            for (int i = 0; i < SQRT_PER_STAGE; i++)
            begin
                ns = sqrt_step(ns, nr[RAD_W-1-2*(j*SQRT_PER_STAGE+i) -: 2]);
                os = sqrt_step(os, orad[RAD_W-1-2*(j*SQRT_PER_STAGE+i) -: 2]);
            end
            new_st_next[j]  = ns;
            old_st_next[j]  = os;
            new_rad_next[j] = nr;
            old_rad_next[j] = orad;
        end
    end

    // Valid bits shift along with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= {valid_reg[SQRT_STAGES-2:0], in_valid};
    end

    // Stage payload registers.
    always_ff @(posedge clk)
    begin
        for (int j = 0; j < SQRT_STAGES; j++)
        begin
            new_st_reg[j]  <= new_st_next[j];
            old_st_reg[j]  <= old_st_next[j];
            new_rad_reg[j] <= new_rad_next[j];
            old_rad_reg[j] <= old_rad_next[j];
            side_reg[j]    <= side_next[j];
        end
    end

    assign out_valid    = valid_reg[SQRT_STAGES-1];
    assign out_root_new = new_st_reg[SQRT_STAGES-1].root;
    assign out_root_old = old_st_reg[SQRT_STAGES-1].root;
    assign out_side     = side_reg[SQRT_STAGES-1];

endmodule

@@ sv/ftrl_div_pipe.sv @@
// Pipelined restoring divider for the weight quotient.
module ftrl_div_pipe (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic [ftrl_pkg::DW-1:0]    in_num,
    input  logic [ftrl_pkg::DEN_W-1:0] in_den,
    input  ftrl_pkg::dv_side_t         in_side,
    output logic                       out_valid,
    output logic [ftrl_pkg::DW-1:0]    out_quot,
    output ftrl_pkg::dv_side_t         out_side
);
    import ftrl_pkg::*;

    logic [DIV_STAGES-1:0] valid_reg;
    div_state_t            st_reg  [DIV_STAGES];
    div_state_t            st_next [DIV_STAGES];
    logic [DW-1:0]         lo_reg  [DIV_STAGES];
    logic [DW-1:0]         lo_next [DIV_STAGES];
    logic [DEN_W-1:0]      den_reg  [DIV_STAGES];
    logic [DEN_W-1:0]      den_next [DIV_STAGES];
    dv_side_t              side_reg  [DIV_STAGES];
    dv_side_t              side_next [DIV_STAGES];

    // The dividend is num shifted up by the fraction; its top part seeds the remainder.
    always_comb
    begin
        div_state_t       s;
        logic [DW-1:0]    lo;
        logic [DEN_W-1:0] d;
        for (int j = 0; j < DIV_STAGES; j++)
        begin
            if (j == 0)
            begin
                s.rem        = DREM_W'(in_num[DW-1:DW-FRAC]);
                s.quot       = '0;
                lo           = {in_num[DW-FRAC-1:0], {FRAC{1'b0}}};
                d            = in_den;
                side_next[j] = in_side;
            end
            else
            begin
                s            = st_reg[j-1];
                lo           = lo_reg[j-1];
                d            = den_reg[j-1];
                side_next[j] = side_reg[j-1];
            end
            for (int i = 0; i < DIV_PER_STAGE; i++)
            begin
                s = div_step(s, lo[DW-1-(j*DIV_PER_STAGE+i)], d);
            end
            st_next[j]  = s;
            lo_next[j]  = lo;
            den_next[j] = d;
        end
    end

    // Valid bits shift along with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= {valid_reg[DIV_STAGES-2:0], in_valid};
    end

    // Stage payload registers.
    always_ff @(posedge clk)
    begin
        for (int j = 0; j < DIV_STAGES; j++)
        begin
            st_reg[j]   <= st_next[j];
            lo_reg[j]   <= lo_next[j];
            den_reg[j]  <= den_next[j];
            side_reg[j] <= side_next[j];
        end
    end

    assign out_valid = valid_reg[DIV_STAGES-1];
    assign out_quot  = st_reg[DIV_STAGES-1].quot;
    assign out_side  = side_reg[DIV_STAGES-1];

endmodule

@@ sv/ftrl_proximal_update_top.sv @@
// FTRL-Proximal per-element update.
// Throughput is one item per cycle; busy never rises and no result is ever held.
// Depth is set by the 12-stage dual square root and the 16-stage quotient divider.
// Reset (rst_n low, asynchronous) empties the pipeline and restores the registers
// to alpha_inv = 1.0, beta = 1.0, lambda_one = 0, lambda_two = 0.
`include "ftrl_proximal_update_top_defines.svh"

module ftrl_proximal_update_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  ftrl_pkg::cmd_t      cmd,
    output logic                done,
    output ftrl_pkg::result_t   result,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  ftrl_pkg::cfg_idx_t  cfg_index,
    input  logic [ftrl_pkg::DW-1:0] cfg_data
);
    import ftrl_pkg::*;

    logic [DW-1:0] alpha_inv_reg;
    logic [DW-1:0] beta_reg;
    logic [DW-1:0] lambda_one_reg;
    logic [DW-1:0] lambda_two_reg;

    // Stage 1 to 3: square of gradient and new sum.
    logic              v1_reg, v2_reg, v3_reg;
    cmd_t              cmd1_reg, cmd2_reg;
    logic [DW-1:0]     gmag1_reg;
    logic [DW-1:0]     gmag_next;
    logic [PROD_W-1:0] gprod2_reg;
    logic [PROD_W-FRAC:0] sqsum;
    logic [DW-1:0]     nn_next;
    sq_side_t          side3_reg;
    logic [DW-1:0]     n3_reg;

    // Square root outputs.
    logic              vq;
    logic [ROOT_W-1:0] root_new;
    logic [ROOT_W-1:0] root_old;
    sq_side_t          sideq;

    // Stages A to F.
    logic              va_reg, vb_reg, vc_reg, vd_reg, ve_reg, vf_reg;
    logic [ROOT_W-1:0] diffa_reg;
    logic [DW:0]       bsum_ext;
    logic [DW-1:0]     bsuma_reg;
    sq_side_t          sidea_reg, sideb_reg, sidec_reg, sided_reg;
    logic [SIGP_W-1:0] sigprodb_reg;
    logic [PROD_W-1:0] denprodb_reg;
    logic [DW-1:0]     sigma_next;
    logic [DW-1:0]     sigmac_reg;
    logic [DEN_W-1:0]  denc_reg, dend_reg, dene_reg, denf_reg;
    logic signed [PROD_W:0] swprodd_reg;
    logic [PROD_W:0]   swadj;
    logic signed [SW_W-1:0] sw;
    logic signed [SW_W+1:0] zsum;
    logic [DW-1:0]     nz_next;
    logic [DW-1:0]     nze_reg;
    logic [DW-1:0]     nne_reg;
    logic [DW-1:0]     zmag;
    logic [DW-1:0]     numf_reg;
    dv_side_t          sidef_reg;

    // Divider outputs and result.
    logic              vdv;
    logic [DW-1:0]     quot;
    dv_side_t          sidedv;
    logic [DW-1:0]     nw_next;
    logic              done_reg;
    result_t           result_reg;
    logic [DW-1:0]     out_zmag;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_inv_reg  <= DW'(1) << FRAC;
            beta_reg       <= DW'(1) << FRAC;
            lambda_one_reg <= '0;
            lambda_two_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_ALPHA_INV:  alpha_inv_reg  <= cfg_data;
                REG_BETA:       beta_reg       <= cfg_data;
                REG_LAMBDA_ONE: lambda_one_reg <= cfg_data;
                REG_LAMBDA_TWO: lambda_two_reg <= cfg_data;
                default:        alpha_inv_reg  <= alpha_inv_reg;
            endcase
        end
    end

    // Valid bits of the stages owned by this module.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            va_reg   <= 1'b0;
            vb_reg   <= 1'b0;
            vc_reg   <= 1'b0;
            vd_reg   <= 1'b0;
            ve_reg   <= 1'b0;
            vf_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= start && !busy;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            va_reg   <= vq;
            vb_reg   <= va_reg;
            vc_reg   <= vb_reg;
            vd_reg   <= vc_reg;
            ve_reg   <= vd_reg;
            vf_reg   <= ve_reg;
            done_reg <= vdv;
        end
    end

    // Gradient magnitude and the saturating new sum.
    always_comb
    begin
        gmag_next = cmd.gradient[DW-1] ? (~cmd.gradient + 1'b1) : cmd.gradient;
        sqsum     = (PROD_W-FRAC+1)'(cmd2_reg.sq_grad_sum)
                  + (PROD_W-FRAC+1)'(gprod2_reg[PROD_W-1:FRAC]);
        nn_next   = (|sqsum[PROD_W-FRAC:DW]) ? '1 : sqsum[DW-1:0];
    end

    always_ff @(posedge clk)
    begin
        cmd1_reg    <= cmd;
        gmag1_reg   <= gmag_next;
        cmd2_reg    <= cmd1_reg;
        gprod2_reg  <= gmag1_reg * gmag1_reg;
        side3_reg.w  <= cmd2_reg.weight;
        side3_reg.z  <= cmd2_reg.z_acc;
        side3_reg.g  <= cmd2_reg.gradient;
        side3_reg.nn <= nn_next;
        n3_reg      <= cmd2_reg.sq_grad_sum;
    end

    ftrl_sqrt_pipe u_sqrt (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (v3_reg),
        .in_rad_new   ({side3_reg.nn, {FRAC{1'b0}}}),
        .in_rad_old   ({n3_reg, {FRAC{1'b0}}}),
        .in_side      (side3_reg),
        .out_valid    (vq),
        .out_root_new (root_new),
        .out_root_old (root_old),
        .out_side     (sideq)
    );

    // Sigma, new z and denominator.
    always_comb
    begin
        bsum_ext   = {1'b0, beta_reg} + (DW+1)'(root_new);
        sigma_next = (|sigprodb_reg[SIGP_W-1:FRAC+DW]) ? '1
                   : sigprodb_reg[FRAC+DW-1:FRAC];
        swadj      = swprodd_reg[PROD_W]
                   ? ($unsigned(swprodd_reg) + {{(PROD_W+1-FRAC){1'b0}}, {FRAC{1'b1}}})
                   : $unsigned(swprodd_reg);
        sw         = $signed(swadj[PROD_W:FRAC]);
        zsum       = (SW_W+2)'($signed(sided_reg.z)) + (SW_W+2)'($signed(sided_reg.g))
                   - (SW_W+2)'(sw);
        if (zsum[SW_W+1] && !(&zsum[SW_W+1:DW-1]))
            nz_next = SMIN;
        else if (!zsum[SW_W+1] && (|zsum[SW_W+1:DW-1]))
            nz_next = SMAX;
        else
            nz_next = zsum[DW-1:0];
        zmag       = nze_reg[DW-1] ? (~nze_reg + 1'b1) : nze_reg;
    end

    always_ff @(posedge clk)
    begin
        diffa_reg    <= root_new - root_old;
        bsuma_reg    <= bsum_ext[DW] ? '1 : bsum_ext[DW-1:0];
        sidea_reg    <= sideq;
        sigprodb_reg <= diffa_reg * alpha_inv_reg;
        denprodb_reg <= bsuma_reg * alpha_inv_reg;
        sideb_reg    <= sidea_reg;
        sigmac_reg   <= sigma_next;
        denc_reg     <= DEN_W'(denprodb_reg[PROD_W-1:FRAC]) + DEN_W'(lambda_two_reg);
        sidec_reg    <= sideb_reg;
        swprodd_reg  <= $signed({1'b0, sigmac_reg}) * $signed(sidec_reg.w);
        dend_reg     <= denc_reg;
        sided_reg    <= sidec_reg;
        nze_reg      <= nz_next;
        nne_reg      <= sided_reg.nn;
        dene_reg     <= dend_reg;
        numf_reg     <= zmag - lambda_one_reg;
        denf_reg     <= dene_reg;
        sidef_reg.nn     <= nne_reg;
        sidef_reg.nz     <= nze_reg;
        sidef_reg.active <= zmag > lambda_one_reg;
        sidef_reg.ovf    <= DEN_W'((zmag - lambda_one_reg) >> (DW - FRAC)) >= dene_reg;
    end

    ftrl_div_pipe u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vf_reg),
        .in_num    (numf_reg),
        .in_den    (denf_reg),
        .in_side   (sidef_reg),
        .out_valid (vdv),
        .out_quot  (quot),
        .out_side  (sidedv)
    );

    // Sign and saturation of the new weight.
    always_comb
    begin
        if (!sidedv.active)
            nw_next = '0;
        else if (sidedv.nz[DW-1])
            nw_next = (sidedv.ovf || quot[DW-1]) ? SMAX : quot;
        else
            nw_next = (sidedv.ovf || (quot > SMIN)) ? SMIN : (~quot + 1'b1);
    end

    always_ff @(posedge clk)
    begin
        result_reg.new_weight      <= $signed(nw_next);
        result_reg.new_sq_grad_sum <= sidedv.nn;
        result_reg.new_z_acc       <= sidedv.nz;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // Magnitude of the delivered z, for the zeroing check.
    assign out_zmag = result_reg.new_z_acc[DW-1] ? (~result_reg.new_z_acc + 1'b1)
                    : result_reg.new_z_acc;

    `FTRL_ASSERT_IMPLIES(a_fixed_latency, start && !busy, ##LATENCY done)
    `FTRL_ASSERT_NEVER(a_no_stray_done, done && !$past(start && !busy, LATENCY))
    `FTRL_ASSERT_IMPLIES(a_weight_sign, done && result.new_weight != '0, result.new_weight[DW-1] != result.new_z_acc[DW-1])
    `FTRL_ASSERT_IMPLIES(a_zero_band, done && out_zmag <= lambda_one_reg, result.new_weight == '0)

endmodule

@@ tb/tb_ftrl_proximal_update_top.sv @@
// Self-checking testbench for the FTRL-Proximal per-element update block.
`timescale 1ns / 1ps

module tb_ftrl_proximal_update_top;
    import ftrl_pkg::*;

    localparam int  NUM_PHASES   = 8;
    localparam int  RAND_PER_PH  = 130;
    localparam int  DRAIN_CYCLES = LATENCY + 8;
    localparam int  CYCLE_LIMIT  = 200000;
    localparam logic [31:0] ONE = 32'h0001_0000;
    localparam logic [31:0] UMAX = 32'hFFFF_FFFF;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    cmd_t        cmd;
    logic        done;
    result_t     result;
    logic        cfg_valid;
    logic        cfg_ready;
    cfg_idx_t    cfg_index;
    logic [DW-1:0] cfg_data;

    // Local copy of the register file.
    logic [31:0] alpha_inv_q;
    logic [31:0] beta_q;
    logic [31:0] lambda_one_q;
    logic [31:0] lambda_two_q;

    result_t     pending_updates[$];
    int          error_count;
    int          cycle_count;

    // One row of the directed stimulus table.
    typedef struct {
        int      phase;
        cmd_t    c;
        bit      typed;
        result_t r;
    } row_t;

    row_t directed_rows[$];

    ftrl_proximal_update_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("ftrl_proximal_update_top regression: fail");
            $finish;
        end
    end

    // Integer square root, one result bit at a time.
    function automatic logic [63:0] int_root(logic [63:0] x);
        logic [63:0] res;
        logic [63:0] trial;
        res = '0;
        for (int b = 27; b >= 0; b--)
        begin
            trial = res | (64'd1 << b);
            if (trial * trial <= x)
                res = trial;
        end
        return res;
    endfunction

    // Expected update for one element under the current register settings.
    function automatic result_t expected_update(cmd_t c);
        longint      w;
        longint      z;
        longint      g;
        longint      sw;
        longint      nz;
        longint      nw;
        logic [63:0] n;
        logic [63:0] gmag;
        logic [63:0] nn;
        logic [63:0] root_new;
        logic [63:0] root_old;
        logic [63:0] sigma;
        logic [63:0] zmag;
        logic [63:0] bsum;
        logic [63:0] den;
        logic [63:0] q;
        result_t     r;
        w = c.weight;
        z = c.z_acc;
        g = c.gradient;
        n = {32'd0, c.sq_grad_sum};
        gmag = (g < 0) ? -g : g;
        nn = n + ((gmag * gmag) >> FRAC);
        if (nn > UMAX)
            nn = UMAX;
        root_new = int_root(nn << FRAC);
        root_old = int_root(n << FRAC);
        sigma = ((root_new - root_old) * alpha_inv_q) >> FRAC;
        if (sigma > UMAX)
            sigma = UMAX;
        sw = (longint'(sigma) * w) / 65536;
        nz = z + g - sw;
        if (nz > 64'sd2147483647)
            nz = 64'sd2147483647;
        if (nz < -64'sd2147483648)
            nz = -64'sd2147483648;
        nw = 0;
        zmag = (nz < 0) ? -nz : nz;
        if (zmag > lambda_one_q)
        begin
            bsum = beta_q + root_new;
            if (bsum > UMAX)
                bsum = UMAX;
            den = ((bsum * alpha_inv_q) >> FRAC) + lambda_two_q;
            if (den == 0)
                q = 64'd1 << 32;
            else
                q = ((zmag - lambda_one_q) << FRAC) / den;
            if (nz < 0)
                nw = (q > 64'd2147483647) ? 64'sd2147483647 : longint'(q);
            else
                nw = (q > 64'd2147483648) ? -64'sd2147483648 : -longint'(q);
        end
        r.new_weight      = nw[31:0];
        r.new_sq_grad_sum = nn[31:0];
        r.new_z_acc       = nz[31:0];
        return r;
    endfunction

    // Compare every result beat with the oldest pending update.
    always @(negedge clk)
    begin
        result_t want;
        if (rst_n && done)
        begin
            if (pending_updates.size() == 0)
            begin
                $error("unexpected result beat");
                error_count++;
            end
            else
            begin
                want = pending_updates.pop_front();
                if (result.new_weight !== want.new_weight)
                begin
                    $error("new_weight: expected %0d, got %0d",
                           want.new_weight, result.new_weight);
                    error_count++;
                end
                if (result.new_sq_grad_sum !== want.new_sq_grad_sum)
                begin
                    $error("new_sq_grad_sum: expected %0d, got %0d",
                           want.new_sq_grad_sum, result.new_sq_grad_sum);
                    error_count++;
                end
                if (result.new_z_acc !== want.new_z_acc)
                begin
                    $error("new_z_acc: expected %0d, got %0d",
                           want.new_z_acc, result.new_z_acc);
                    error_count++;
                end
            end
        end
    end

    // One register write beat; the caller keeps the block idle.
    task automatic write_reg(cfg_idx_t idx, logic [31:0] value);
        bit ok;
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
        begin
            @(negedge clk);
            ok = cfg_ready;
            @(posedge clk);
        end
        while (!ok);
        cfg_valid <= 1'b0;
        case (idx)
            REG_ALPHA_INV:  alpha_inv_q  = value;
            REG_BETA:       beta_q       = value;
            REG_LAMBDA_ONE: lambda_one_q = value;
            REG_LAMBDA_TWO: lambda_two_q = value;
        endcase
    endtask

    // Mix of full-range, small and extreme register values.
    function automatic logic [31:0] pick_reg();
        case ($urandom_range(0, 4))
            0:       return $urandom();
            1:       return $urandom_range(0, 4 * ONE);
            2:       return ONE;
            3:       return $urandom_range(0, 255);
            default: return $urandom_range(ONE / 4, 2 * ONE);
        endcase
    endfunction

    // Drain the pipeline, then load the settings for one phase.
    task automatic enter_phase(int ph);
        start <= 1'b0;
        wait (pending_updates.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        case (ph)
            1:
            begin
                write_reg(REG_ALPHA_INV, '0);
                write_reg(REG_BETA, '0);
                write_reg(REG_LAMBDA_ONE, '0);
                write_reg(REG_LAMBDA_TWO, '0);
            end
            2:
            begin
                write_reg(REG_ALPHA_INV, UMAX);
                write_reg(REG_BETA, UMAX);
                write_reg(REG_LAMBDA_ONE, UMAX);
                write_reg(REG_LAMBDA_TWO, UMAX);
            end
            default:
            begin
                write_reg(REG_ALPHA_INV, pick_reg());
                write_reg(REG_BETA, pick_reg());
                write_reg(REG_LAMBDA_ONE, pick_reg());
                write_reg(REG_LAMBDA_TWO, pick_reg());
            end
        endcase
    endtask

    // Send one command beat after a random gap; start stays high if the gap is zero.
    task automatic send_cmd(cmd_t c, bit typed, result_t r);
        int gap;
        bit ok;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
        if ($urandom_range(0, 1) == 0)
            gap = 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        cmd   <= c;
        do
        begin
            @(negedge clk);
            ok = !busy;
            @(posedge clk);
        end
        while (!ok);
        pending_updates.push_back(typed ? r : expected_update(c));
    endtask

    // Operand values with extremes and small magnitudes well represented.
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return SMAX;
            2:       return SMIN;
            3:       return UMAX;
            4, 5:    return $urandom();
            default: return $urandom_range(0, 8 * ONE) - 4 * ONE;
        endcase
    endfunction

    task automatic add_row(int ph, logic [31:0] w, logic [31:0] n, logic [31:0] z,
                           logic [31:0] g, bit typed, logic [31:0] ew,
                           logic [31:0] en, logic [31:0] ez);
        row_t row;
        row.phase = ph;
        row.c     = '{weight: w, sq_grad_sum: n, z_acc: z, gradient: g};
        row.typed = typed;
        row.r     = '{new_weight: ew, new_sq_grad_sum: en, new_z_acc: ez};
        directed_rows.push_back(row);
    endtask

    initial
    begin
        int   cur_phase;
        cmd_t c;
        rst_n        = 1'b0;
        start        = 1'b0;
        cmd          = '0;
        cfg_valid    = 1'b0;
        cfg_index    = REG_ALPHA_INV;
        cfg_data     = '0;
        error_count  = 0;
        cycle_count  = 0;
        alpha_inv_q  = ONE;
        beta_q       = ONE;
        lambda_one_q = '0;
        lambda_two_q = '0;

        // Reset settings: zero input, plain positive and negative z, then the field extremes.
        add_row(0, 0, 0, 0, 0, 1, 0, 0, 0);
        add_row(0, 0, 0, ONE, 0, 1, -ONE, 0, ONE);
        add_row(0, 0, 0, -ONE, 0, 1, ONE, 0, -ONE);
        add_row(0, SMAX, 0, 0, SMAX, 0, 0, 0, 0);
        add_row(0, SMIN, 0, 0, SMIN, 0, 0, 0, 0);
        add_row(0, SMAX, UMAX, SMAX, SMAX, 0, 0, 0, 0);
        add_row(0, SMIN, UMAX, SMIN, SMIN, 0, 0, 0, 0);
        add_row(0, ONE, ONE, ONE, ONE, 0, 0, 0, 0);
        add_row(0, -ONE, 4 * ONE, -ONE, -ONE, 0, 0, 0, 0);
        add_row(0, SMAX, 0, SMIN, SMAX, 0, 0, 0, 0);
        add_row(0, SMIN, 0, SMAX, SMIN, 0, 0, 0, 0);
        add_row(0, 1, 1, 1, 1, 0, 0, 0, 0);
        add_row(0, UMAX, UMAX, UMAX, UMAX, 0, 0, 0, 0);
        // All registers zero: the denominator vanishes and the weight saturates.
        add_row(1, 0, 0, ONE, 0, 1, SMIN, 0, ONE);
        add_row(1, 0, 0, -ONE, 0, 1, SMAX, 0, -ONE);
        add_row(1, SMAX, 0, SMAX, SMAX, 0, 0, 0, 0);
        add_row(1, 0, 0, 0, 0, 1, 0, 0, 0);
        // All registers at their maximum: threshold never crossed, sums saturate.
        add_row(2, SMAX, 0, SMAX, SMIN, 0, 0, 0, 0);
        add_row(2, SMIN, UMAX, SMIN, SMAX, 0, 0, 0, 0);
        add_row(2, ONE, 0, -ONE, ONE, 0, 0, 0, 0);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        cur_phase = 0;
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].phase != cur_phase)
            begin
                // Random items for the phase just left, except the reset phase.
                if (cur_phase > 0)
                    for (int k = 0; k < RAND_PER_PH; k++)
                    begin
                        c = '{pick_word(), pick_word(), pick_word(), pick_word()};
                        send_cmd(c, 0, '0);
                    end
                cur_phase = directed_rows[i].phase;
                enter_phase(cur_phase);
            end
            send_cmd(directed_rows[i].c, directed_rows[i].typed, directed_rows[i].r);
        end

        for (int ph = cur_phase; ph < NUM_PHASES; ph++)
        begin
            if (ph != cur_phase)
                enter_phase(ph);
            for (int k = 0; k < RAND_PER_PH; k++)
            begin
                c = '{pick_word(), pick_word(), pick_word(), pick_word()};
                send_cmd(c, 0, '0);
            end
        end
        start <= 1'b0;

        wait (pending_updates.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("ftrl_proximal_update_top regression: pass");
        else
            $display("ftrl_proximal_update_top regression: fail");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+sv
sv/ftrl_pkg.sv
sv/ftrl_sqrt_pipe.sv
sv/ftrl_div_pipe.sv
sv/ftrl_proximal_update_top.sv
tb/tb_ftrl_proximal_update_top.sv
